// File: design/ferq_pkg.sv
// ----------------------------------------------------------------------------
// ferq_pkg
// Shared types and constants of the framed event ring queue: command and
// status codes, register map and the packed item types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package ferq_pkg;

  // Default ring storage depth in bytes
  localparam int DEPTH_DEF = 1024;

  // Largest payload a record may carry
  localparam int MAX_PAYLOAD = 64;

  // Record header: id byte and length byte
  localparam int HDR_BYTES = 2;

  // Capacity register
  localparam int CAP_REG_W = 11;
  localparam int CAP_RESET = 1024;
  localparam int CAP_MIN   = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_CAPACITY = 1'b0;

  // Stored and reported payload length width
  localparam int LEN_W = 7;

  // Command codes
  localparam logic [1:0] CMD_PUT_START = 2'd0;
  localparam logic [1:0] CMD_PUT_BYTE  = 2'd1;
  localparam logic [1:0] CMD_GET       = 2'd2;

  // Status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;
  localparam logic [1:0] STS_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] event_id;
    logic [7:0] data_length;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       out_event_id;
    logic [LEN_W-1:0] out_length;
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             last;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/framed_event_ring_queue.sv
// ----------------------------------------------------------------------------
// framed_event_ring_queue
// Byte ring queue of framed records (id, length, payload) kept in one
// synchronous RAM, with an APB-style capacity register.
// ----------------------------------------------------------------------------
// A put_byte item is answered from ST_IDLE; a put_start item also passes
// through ST_HDR (the id and length bytes go through the single RAM write port
// one per cycle). A get item walks ST_GID and ST_GLEN, then ST_GBODY for a
// record with payload; an empty queue answer and other failed commands come
// from ST_IDLE. The get walk reads the id and length bytes through the RAM
// read port, then gives one result per cycle while the output side takes
// them. Ring capacity is clamped to [2, DEPTH]; writing it empties the queue.
// Results are held in one output register; a stalled output holds the walk.
`default_nettype none

module framed_event_ring_queue
  import ferq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  // Configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int AW     = $clog2(DEPTH);
  localparam int DW     = $clog2(DEPTH + 1);
  localparam int CW     = (DW > CAP_REG_W) ? DW : CAP_REG_W;
  localparam int CapRst = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_GID,
    ST_GLEN,
    ST_GBODY
  } state_t;

  // Registers
  state_t                 state_r, state_nxt;
  logic [CAP_REG_W-1:0]   cap_raw_r, cap_raw_nxt;
  logic [CW-1:0]          cap_r, cap_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [AW-1:0]          rp_r, rp_nxt;
  logic [CW-1:0]          free_r, free_nxt;
  logic                   put_open_r, put_open_nxt;
  logic [LEN_W-1:0]       put_rem_r, put_rem_nxt;
  logic [LEN_W-1:0]       put_total_r, put_total_nxt;
  logic [LEN_W-1:0]       hdr_len_r, hdr_len_nxt;
  logic [7:0]             get_id_r, get_id_nxt;
  logic [LEN_W-1:0]       get_len_r, get_len_nxt;
  logic [LEN_W-1:0]       get_cnt_r, get_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  // Ring memory
  logic [7:0]             mem [DEPTH];
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [7:0]             mem_wdata;
  logic [7:0]             mem_rdata_r;

  // Misc combinational
  logic                   cfg_wr;
  logic                   out_free;
  logic                   emit;
  out_item_t              emit_data;
  logic [CW-1:0]          cfg_val;
  logic [CW-1:0]          need;
  logic [LEN_W-1:0]       rd_len;

  // Step a pointer, wrapping at the ring capacity
  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    return (n >= cap) ? '0 : n[AW-1:0];
  endfunction

  // Give space back, saturating at capacity
  function automatic logic [CW-1:0] give_back(input logic [CW-1:0] free,
                                              input logic [CW-1:0] gained,
                                              input logic [CW-1:0] cap);
    return ((cap - free) > gained) ? (free + gained) : cap;
  endfunction

  // Take space, saturating at zero
  function automatic logic [CW-1:0] take(input logic [CW-1:0] free,
                                         input logic [CW-1:0] used);
    return (free >= used) ? (free - used) : '0;
  endfunction

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_IDX_CAPACITY);
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_CAPACITY) ?
                      CFG_DATA_W'(cap_raw_r) : '0;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cfg_val = CW'(cfg_pwdata[CAP_REG_W-1:0]);
  assign need    = CW'(in_data.data_length) + CW'(HDR_BYTES);
  assign rd_len  = (mem_rdata_r > 8'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                   : mem_rdata_r[LEN_W-1:0];

  // Next state and command handling
  always_comb begin
    state_nxt     = state_r;
    cap_raw_nxt   = cap_raw_r;
    cap_nxt       = cap_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    free_nxt      = free_r;
    put_open_nxt  = put_open_r;
    put_rem_nxt   = put_rem_r;
    put_total_nxt = put_total_r;
    hdr_len_nxt   = hdr_len_r;
    get_id_nxt    = get_id_r;
    get_len_nxt   = get_len_r;
    get_cnt_nxt   = get_cnt_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = wp_r;
    mem_raddr     = rp_r;
    mem_wdata     = in_data.data_byte;
    emit          = 1'b0;
    emit_data     = '0;
    emit_data.last = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          emit = 1'b1;
          unique case (in_data.command)
            CMD_PUT_START: begin
              if (put_open_r || (in_data.data_length > 8'(MAX_PAYLOAD))) begin
                emit_data.status = STS_BAD;
              end else if (free_r < need) begin
                emit_data.status = STS_FULL;
              end else begin
                // Write the id byte; the length byte follows in ST_HDR
                emit_data.status = STS_OK;
                mem_we      = 1'b1;
                mem_wdata   = in_data.event_id;
                wp_nxt      = advance(wp_r, cap_r);
                hdr_len_nxt = in_data.data_length[LEN_W-1:0];
                state_nxt   = ST_HDR;
              end
            end
            CMD_PUT_BYTE: begin
              if (!put_open_r) begin
                emit_data.status = STS_BAD;
              end else begin
                emit_data.status = STS_OK;
                mem_we      = 1'b1;
                wp_nxt      = advance(wp_r, cap_r);
                put_rem_nxt = put_rem_r - LEN_W'(1);
                // Commit the record on its last byte
                if (put_rem_r == LEN_W'(1)) begin
                  free_nxt     = take(free_r, CW'(put_total_r) + CW'(HDR_BYTES));
                  put_open_nxt = 1'b0;
                end
              end
            end
            CMD_GET: begin
              if (free_r >= cap_r) begin
                emit_data.status = STS_EMPTY;
              end else begin
                // Read the id byte
                emit      = 1'b0;
                mem_re    = 1'b1;
                rp_nxt    = advance(rp_r, cap_r);
                state_nxt = ST_GID;
              end
            end
            default: begin
              emit_data.status = STS_BAD;
            end
          endcase
        end
      end

      ST_HDR: begin
        // Write the length byte and open or commit the record
        mem_we        = 1'b1;
        mem_wdata     = 8'(hdr_len_r);
        wp_nxt        = advance(wp_r, cap_r);
        put_total_nxt = hdr_len_r;
        put_rem_nxt   = hdr_len_r;
        put_open_nxt  = (hdr_len_r != '0);
        if (hdr_len_r == '0) begin
          free_nxt = take(free_r, CW'(HDR_BYTES));
        end
        state_nxt = ST_IDLE;
      end

      ST_GID: begin
        // Capture id, read the length byte
        get_id_nxt = mem_rdata_r;
        mem_re     = 1'b1;
        rp_nxt     = advance(rp_r, cap_r);
        state_nxt  = ST_GLEN;
      end

      ST_GLEN: begin
        if (rd_len == '0) begin
          // Empty record: one result, hold until the output slot frees
          if (out_free) begin
            emit                   = 1'b1;
            emit_data.status       = STS_OK;
            emit_data.out_event_id = get_id_r;
            free_nxt  = give_back(free_r, CW'(HDR_BYTES), cap_r);
            state_nxt = ST_IDLE;
          end
        end else begin
          get_len_nxt = rd_len;
          get_cnt_nxt = rd_len;
          mem_re      = 1'b1;
          rp_nxt      = advance(rp_r, cap_r);
          state_nxt   = ST_GBODY;
        end
      end

      ST_GBODY: begin
        // Emit one payload byte per cycle while the output slot is free, prefetch the next
        if (out_free) begin
          emit                   = 1'b1;
          emit_data.status       = STS_OK;
          emit_data.out_event_id = get_id_r;
          emit_data.out_length   = get_len_r;
          emit_data.out_byte     = mem_rdata_r;
          emit_data.byte_valid   = 1'b1;
          emit_data.last         = (get_cnt_r == LEN_W'(1));
          if (get_cnt_r == LEN_W'(1)) begin
            free_nxt  = give_back(free_r, CW'(get_len_r) + CW'(HDR_BYTES), cap_r);
            state_nxt = ST_IDLE;
          end else begin
            get_cnt_nxt = get_cnt_r - LEN_W'(1);
            mem_re      = 1'b1;
            rp_nxt      = advance(rp_r, cap_r);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Capacity write: clamp and empty the queue
    if (cfg_wr) begin
      cap_raw_nxt = cfg_pwdata[CAP_REG_W-1:0];
      if (cfg_val < CW'(CAP_MIN)) begin
        cap_nxt = CW'(CAP_MIN);
      end else if (cfg_val > CW'(DEPTH)) begin
        cap_nxt = CW'(DEPTH);
      end else begin
        cap_nxt = cfg_val;
      end
      wp_nxt        = '0;
      rp_nxt        = '0;
      free_nxt      = cap_nxt;
      put_open_nxt  = 1'b0;
      put_rem_nxt   = '0;
      put_total_nxt = '0;
      state_nxt     = ST_IDLE;
    end

    // Output register
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_data_nxt  = out_data_r;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_raw_r   <= CAP_REG_W'(CAP_RESET);
      cap_r       <= CW'(CapRst);
      wp_r        <= '0;
      rp_r        <= '0;
      free_r      <= CW'(CapRst);
      put_open_r  <= 1'b0;
      put_rem_r   <= '0;
      put_total_r <= '0;
      get_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_raw_r   <= cap_raw_nxt;
      cap_r       <= cap_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      free_r      <= free_nxt;
      put_open_r  <= put_open_nxt;
      put_rem_r   <= put_rem_nxt;
      put_total_r <= put_total_nxt;
      get_cnt_r   <= get_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hdr_len_r  <= hdr_len_nxt;
    get_id_r   <= get_id_nxt;
    get_len_r  <= get_len_nxt;
    out_data_r <= out_data_nxt;
  end

  // Ring RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // Free space never exceeds the ring capacity
  assert property (@(posedge clk) disable iff (!rst_n) free_r <= cap_r)
    else $error("free space above capacity");

  // Both pointers stay inside the ring
  assert property (@(posedge clk) disable iff (!rst_n)
                   (CW'(wp_r) < cap_r) && (CW'(rp_r) < cap_r))
    else $error("ring pointer out of range");

  // An open put always has bytes still to come
  assert property (@(posedge clk) disable iff (!rst_n)
                   put_open_r |-> (put_rem_r != '0))
    else $error("open put with nothing remaining");

  // Payload walk count stays within the record length
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_GBODY) |->
                   ((get_cnt_r != '0) && (get_cnt_r <= get_len_r)))
    else $error("payload count out of range");

  // The RAM is never read and written in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
    else $error("RAM read and write overlap");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks framed_event_ring_queue against a cycle-free predictor of its ring
// queue. Directed items cover the commands and the error cases, then random
// record traffic, paced and unpaced, runs at several capacities. Every
// result is matched field by field against the predicted result list.
// ----------------------------------------------------------------------------
module testbench;
  import ferq_pkg::*;

  // Command 3 has no meaning and must be rejected
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] CAP_ADDR = CFG_ADDR_W'(4 * REG_IDX_CAPACITY);
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LEN = 16;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Predicted ring contents and pointers
  logic [7:0]  ring_copy [DEPTH_DEF];
  logic [10:0] ring_cap;
  logic [9:0]  wr_ptr;
  logic [9:0]  rd_ptr;
  logic [10:0] free_cnt;
  logic        rec_open;
  logic [6:0]  rec_left;
  logic [6:0]  rec_len;

  out_item_t due_results [$];
  int        fail_cnt = 0;
  int        items_sent = 0;
  int        quiet_cycles = 0;
  int        hold_left = 0;
  int        stall_left = 0;
  bit        pacing_on = 1'b1;

  framed_event_ring_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  function automatic void restart_ring();
    wr_ptr   = '0;
    rd_ptr   = '0;
    free_cnt = ring_cap;
    rec_open = 1'b0;
    rec_left = '0;
    rec_len  = '0;
  endfunction

  function automatic logic [9:0] ring_next(input logic [9:0] p);
    return ((11'(p) + 11'd1) >= ring_cap) ? 10'd0 : p + 10'd1;
  endfunction

  function automatic out_item_t status_only(input logic [1:0] sts);
    out_item_t res;
    res        = '0;
    res.status = sts;
    res.last   = 1'b1;
    return res;
  endfunction

  // Count the finished record as used space
  function automatic void close_record();
    int used;
    used     = int'(rec_len) + HDR_BYTES;
    free_cnt = (int'(free_cnt) >= used) ? free_cnt - 11'(used) : 11'd0;
    rec_open = 1'b0;
    rec_left = '0;
  endfunction

  function automatic void predict_queue_op(input in_item_t it);
    out_item_t  res;
    logic [7:0] rid;
    int         rlen;
    int         gained;
    int         k;
    case (it.command)
      CMD_PUT_START: begin
        if (rec_open || it.data_length > MAX_PAYLOAD) begin
          due_results.push_back(status_only(STS_BAD));
        end else if (int'(free_cnt) < int'(it.data_length) + HDR_BYTES) begin
          due_results.push_back(status_only(STS_FULL));
        end else begin
          ring_copy[wr_ptr] = it.event_id;
          wr_ptr = ring_next(wr_ptr);
          ring_copy[wr_ptr] = it.data_length;
          wr_ptr = ring_next(wr_ptr);
          rec_len  = it.data_length[6:0];
          rec_left = it.data_length[6:0];
          rec_open = 1'b1;
          if (rec_len == 0) close_record();
          due_results.push_back(status_only(STS_OK));
        end
      end
      CMD_PUT_BYTE: begin
        if (!rec_open) begin
          due_results.push_back(status_only(STS_BAD));
        end else begin
          ring_copy[wr_ptr] = it.data_byte;
          wr_ptr = ring_next(wr_ptr);
          if (rec_left > 0) rec_left = rec_left - 7'd1;
          if (rec_left == 0) close_record();
          due_results.push_back(status_only(STS_OK));
        end
      end
      CMD_GET: begin
        if (free_cnt >= ring_cap) begin
          due_results.push_back(status_only(STS_EMPTY));
        end else begin
          rid = ring_copy[rd_ptr];
          rd_ptr = ring_next(rd_ptr);
          rlen = int'(ring_copy[rd_ptr]);
          rd_ptr = ring_next(rd_ptr);
          if (rlen > MAX_PAYLOAD) rlen = MAX_PAYLOAD;
          if (rlen == 0) begin
            res = status_only(STS_OK);
            res.out_event_id = rid;
            due_results.push_back(res);
          end else begin
            for (k = 0; k < rlen; k++) begin
              res              = '0;
              res.status       = STS_OK;
              res.out_event_id = rid;
              res.out_length   = LEN_W'(rlen);
              res.out_byte     = ring_copy[rd_ptr];
              res.byte_valid   = 1'b1;
              res.last         = (k == rlen - 1);
              rd_ptr = ring_next(rd_ptr);
              due_results.push_back(res);
            end
          end
          gained = rlen + HDR_BYTES;
          free_cnt = (int'(ring_cap) - int'(free_cnt) > gained) ?
                     free_cnt + 11'(gained) : ring_cap;
        end
      end
      default: due_results.push_back(status_only(STS_BAD));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Predict accepted items and check accepted results
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_queue_op(in_data);
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: sts=%0d id=%02h len=%0d byte=%02h bv=%0b last=%0b",
                     out_data.status, out_data.out_event_id, out_data.out_length,
                     out_data.out_byte, out_data.byte_valid, out_data.last);
        end else begin
          want = due_results.pop_front();
          if (out_data !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("mismatch: expected sts=%0d id=%02h len=%0d byte=%02h bv=%0b last=%0b",
                       want.status, want.out_event_id, want.out_length,
                       want.out_byte, want.byte_valid, want.last);
              $display("          actual   sts=%0d id=%02h len=%0d byte=%02h bv=%0b last=%0b",
                       out_data.status, out_data.out_event_id, out_data.out_length,
                       out_data.out_byte, out_data.byte_valid, out_data.last);
            end
          end
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int draw_pause();
    int r;
    if (!pacing_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: a long hold-off when one is set, else random stalls
  always begin : pace_results
    @(negedge clk);
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = draw_pause();
    end
  end

  // ------------------------------------------------------------------------
  // Item sending
  // ------------------------------------------------------------------------
  function automatic in_item_t pack_item(input logic [1:0] cmd, input logic [7:0] id,
                                         input logic [7:0] len, input logic [7:0] b);
    in_item_t it;
    it.command     = cmd;
    it.event_id    = id;
    it.data_length = len;
    it.data_byte   = b;
    return it;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_pause();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_start(input logic [7:0] id, input logic [7:0] len);
    send_item(pack_item(CMD_PUT_START, id, len, 8'($urandom_range(0, 255))));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(pack_item(CMD_PUT_BYTE, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), b));
  endtask

  task automatic send_get();
    send_item(pack_item(CMD_GET, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Write the capacity register while the block is idle
  task automatic write_capacity(input logic [31:0] value);
    logic [CAP_REG_W-1:0] raw;
    wait_for_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    raw = value[CAP_REG_W-1:0];
    if (raw < CAP_MIN) ring_cap = 11'(CAP_MIN);
    else if (raw > DEPTH_DEF) ring_cap = 11'(DEPTH_DEF);
    else ring_cap = raw;
    restart_ring();
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Every command and error case at the reset capacity
  task automatic test_directed_ops();
    send_get();
    send_byte(8'hFF);
    send_item(pack_item(CMD_UNDEFINED, 8'hFF, 8'hFF, 8'hFF));
    send_start(8'h12, 8'd65);
    send_start(8'hFF, 8'd255);
    send_start(8'hFF, 8'd0);
    send_get();
    send_start(8'h00, 8'd3);
    send_start(8'h77, 8'd1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    // get while a put is open pops only the committed record
    send_start(8'h3C, 8'd2);
    send_get();
    send_byte(8'h5A);
    send_byte(8'hC3);
    send_get();
    send_get();
  endtask

  // Clamped capacities, exact fits, wrap and abandon on capacity write
  task automatic test_capacity_limits();
    int k;
    write_capacity(32'd0);
    send_start(8'hC3, 8'd0);
    send_start(8'h11, 8'd0);
    send_get();
    send_get();
    write_capacity(32'd1);
    send_start(8'h22, 8'd1);
    write_capacity(32'd2);
    send_start(8'h5A, 8'd0);
    send_get();
    // seven-byte ring: offset the pointers, then a record that wraps
    write_capacity(32'd7);
    send_start(8'h81, 8'd2);
    send_byte(8'h01);
    send_byte(8'h02);
    send_get();
    send_start(8'h82, 8'd5);
    for (k = 0; k < 5; k++) send_byte(8'($urandom_range(0, 255)));
    send_start(8'h83, 8'd0);
    send_get();
    // open put is dropped by a capacity write
    send_start(8'h84, 8'd4);
    send_byte(8'h10);
    write_capacity(32'd7);
    send_byte(8'h20);
    send_get();
  endtask

  // Mostly well-formed records with random content, some gets and noise
  task automatic test_random_traffic(input logic [31:0] cap_value, input int n_items,
                                     input bit paced);
    int first;
    int pick;
    int len;
    int k;
    write_capacity(cap_value);
    pacing_on = paced;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(33, MAX_PAYLOAD)
                                           : $urandom_range(0, 8);
        send_start(8'($urandom_range(0, 255)), 8'(len));
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 29) == 0) send_get();
          if ($urandom_range(0, 39) == 0)
            send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          send_byte(8'($urandom_range(0, 255)));
        end
      end else if (pick < 85) begin
        send_get();
      end else begin
        case ($urandom_range(0, 2))
          0: send_item(pack_item(CMD_UNDEFINED, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
          1: send_start(8'($urandom_range(0, 255)),
                        8'($urandom_range(MAX_PAYLOAD + 1, 255)));
          default: send_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
    pacing_on = 1'b1;
  endtask

  // Hold the result side off while a record streams in
  task automatic test_stalled_receiver();
    int k;
    write_capacity(32'd1024);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    send_start(8'hE7, 8'(STALL_LEN));
    for (k = 0; k < STALL_LEN; k++) send_byte(8'($urandom_range(0, 255)));
    send_get();
    // pause the sender until the whole record is back
    wait_for_results();
    send_get();
  endtask

  initial begin : run_tests
    ring_cap = 11'(CAP_RESET);
    restart_ring();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_capacity_limits();
    test_random_traffic(32'd40, 30, 1'b1);
    test_random_traffic(32'hA5A5_0014, 15, 1'b1);
    test_random_traffic(32'h0000_07FF, 25, 1'b0);
    test_stalled_receiver();

    wait_for_results();
    repeat (20) @(posedge clk);
    fail_cnt += due_results.size();
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
